FILE: rtl/core/mlfp_pkg.sv
// Shared types and constants for the marker/length frame parser.
// No dependencies; used by marker_length_frame_parser.
`timescale 1ns / 1ps
`default_nettype none

package mlfp_pkg;

    // Byte and length widths of the frame format.
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned LengthWidth = 16;

    // Configuration register indexes and the index port width.
    localparam int unsigned CfgIndexWidth = 1;
    localparam logic [CfgIndexWidth-1:0] CfgMarkerFirst  = 1'b0;
    localparam logic [CfgIndexWidth-1:0] CfgMarkerSecond = 1'b1;

    // Reset values of the start-of-frame marker bytes.
    localparam logic [ByteWidth-1:0] MarkerFirstReset  = 8'h5A;
    localparam logic [ByteWidth-1:0] MarkerSecondReset = 8'h9E;

    // Parser phase, one per byte position in the frame header, plus the payload phase.
    typedef enum logic [3:0] {
        PH_MARK1   = 4'd0,
        PH_MARK2   = 4'd1,
        PH_CSUM    = 4'd2,
        PH_FLAG    = 4'd3,
        PH_TYPE    = 4'd4,
        PH_CMD     = 4'd5,
        PH_LENHI   = 4'd6,
        PH_LENLO   = 4'd7,
        PH_PAYLOAD = 4'd8
    } parse_phase_t;

    // One result transaction, as held in the output register.
    typedef struct packed {
        logic [ByteWidth-1:0]   data_byte;
        logic                   has_data;
        logic                   end_of_frame;
        logic [ByteWidth-1:0]   hdr_checksum;
        logic [ByteWidth-1:0]   hdr_flag;
        logic [ByteWidth-1:0]   hdr_type;
        logic [ByteWidth-1:0]   hdr_command;
        logic [LengthWidth-1:0] frame_length;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/marker_length_frame_parser.sv
// Top level of the marker/length frame parser: header state machine and output register.
// Depends on mlfp_pkg for the phase type, result struct and constants.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   Direction  Handshake             Contents
//  in        to block   in_valid / in_stall   rx_byte
//  out       from block out_valid / out_stall data_byte, flags, header fields, frame_length
//  cfg       to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  Every received byte moves the phase register and, for a payload byte or an
//  empty frame, loads the output register in the same edge.
//  A result appears in the cycle after its byte is accepted.
//  in_stall rises only while the output register holds a result that is stalled.
//  Reset is asynchronous and returns the markers to 0x5A / 0x9E and the parser
//  to hunting for the first marker byte.

module marker_length_frame_parser
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input byte channel.
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [mlfp_pkg::ByteWidth-1:0]      rx_byte,
    // Result channel.
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [mlfp_pkg::ByteWidth-1:0]           data_byte,
    output logic                                     has_data,
    output logic                                     end_of_frame,
    output logic [mlfp_pkg::ByteWidth-1:0]           hdr_checksum,
    output logic [mlfp_pkg::ByteWidth-1:0]           hdr_flag,
    output logic [mlfp_pkg::ByteWidth-1:0]           hdr_type,
    output logic [mlfp_pkg::ByteWidth-1:0]           hdr_command,
    output logic [mlfp_pkg::LengthWidth-1:0]         frame_length,
    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mlfp_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  wire logic [mlfp_pkg::ByteWidth-1:0]      cfg_data
);

    localparam int unsigned BW = mlfp_pkg::ByteWidth;
    localparam int unsigned LW = mlfp_pkg::LengthWidth;

    // Configuration registers.
    logic [BW-1:0] marker_first_reg;
    logic [BW-1:0] marker_second_reg;

    // Parser state.
    mlfp_pkg::parse_phase_t phase_reg, phase_next;
    logic [BW-1:0] checksum_reg, checksum_next;
    logic [BW-1:0] flag_reg, flag_next;
    logic [BW-1:0] type_reg, type_next;
    logic [BW-1:0] command_reg, command_next;
    logic [LW-1:0] length_reg, length_next;
    logic [LW-1:0] count_reg, count_next;

    // Output register.
    logic               out_valid_reg;
    mlfp_pkg::result_t  result_reg;
    mlfp_pkg::result_t  result_next;
    logic               emit;

    logic          in_accept;
    logic          out_accept;
    logic [LW:0]   count_inc;
    logic          last_byte;
    logic [LW-1:0] length_full;

    assign cfg_ready  = 1'b1;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    assign count_inc   = {1'b0, count_reg} + {{LW{1'b0}}, 1'b1};
    assign last_byte   = (count_inc >= {1'b0, length_reg});
    assign length_full = {length_reg[LW-1:BW], rx_byte};

    // Configuration writes; indexes outside the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_first_reg  <= mlfp_pkg::MarkerFirstReset;
            marker_second_reg <= mlfp_pkg::MarkerSecondReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mlfp_pkg::CfgMarkerFirst:  marker_first_reg  <= cfg_data;
                mlfp_pkg::CfgMarkerSecond: marker_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and result for the byte on rx_byte.
    always_comb
    begin
        phase_next    = phase_reg;
        checksum_next = checksum_reg;
        flag_next     = flag_reg;
        type_next     = type_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        emit          = 1'b0;

        result_next.data_byte    = '0;
        result_next.has_data     = 1'b0;
        result_next.end_of_frame = 1'b0;
        result_next.hdr_checksum = checksum_reg;
        result_next.hdr_flag     = flag_reg;
        result_next.hdr_type     = type_reg;
        result_next.hdr_command  = command_reg;
        result_next.frame_length = length_reg;

        case (phase_reg)
            mlfp_pkg::PH_MARK2:
            begin
                // A second match to the first marker keeps waiting.
                if (rx_byte == marker_second_reg)
                    phase_next = mlfp_pkg::PH_CSUM;
                else if (rx_byte != marker_first_reg)
                    phase_next = mlfp_pkg::PH_MARK1;
            end
            mlfp_pkg::PH_CSUM:
            begin
                checksum_next = rx_byte;
                phase_next    = mlfp_pkg::PH_FLAG;
            end
            mlfp_pkg::PH_FLAG:
            begin
                flag_next  = rx_byte;
                phase_next = mlfp_pkg::PH_TYPE;
            end
            mlfp_pkg::PH_TYPE:
            begin
                type_next  = rx_byte;
                phase_next = mlfp_pkg::PH_CMD;
            end
            mlfp_pkg::PH_CMD:
            begin
                command_next = rx_byte;
                phase_next   = mlfp_pkg::PH_LENHI;
            end
            mlfp_pkg::PH_LENHI:
            begin
                length_next = {rx_byte, {BW{1'b0}}};
                phase_next  = mlfp_pkg::PH_LENLO;
            end
            mlfp_pkg::PH_LENLO:
            begin
                length_next = length_full;
                count_next  = '0;
                if (length_full != '0)
                begin
                    phase_next = mlfp_pkg::PH_PAYLOAD;
                end
                else
                begin
                    // Empty frame: one notice without data, then back to hunting.
                    emit                     = 1'b1;
                    result_next.end_of_frame = 1'b1;
                    result_next.frame_length = '0;
                    phase_next               = mlfp_pkg::PH_MARK1;
                end
            end
            mlfp_pkg::PH_PAYLOAD:
            begin
                emit                     = 1'b1;
                result_next.data_byte    = rx_byte;
                result_next.has_data     = 1'b1;
                result_next.end_of_frame = last_byte;
                if (last_byte)
                    phase_next = mlfp_pkg::PH_MARK1;
                else
                    count_next = count_inc[LW-1:0];
            end
            default:
            begin
                // Hunting: everything but the first marker byte is dropped.
                if (rx_byte == marker_first_reg)
                    phase_next = mlfp_pkg::PH_MARK2;
                else
                    phase_next = mlfp_pkg::PH_MARK1;
            end
        endcase

        // Returning to hunting always clears the header state.
        if (phase_next == mlfp_pkg::PH_MARK1)
        begin
            checksum_next = '0;
            flag_next     = '0;
            type_next     = '0;
            command_next  = '0;
            length_next   = '0;
            count_next    = '0;
        end
    end

    // Parser state registers, updated once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mlfp_pkg::PH_MARK1;
            checksum_reg <= '0;
            flag_reg     <= '0;
            type_reg     <= '0;
            command_reg  <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
        end
        else if (in_accept)
        begin
            phase_reg    <= phase_next;
            checksum_reg <= checksum_next;
            flag_reg     <= flag_next;
            type_reg     <= type_next;
            command_reg  <= command_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
        end
    end

    // Output register: loads on a producing byte, empties when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= emit;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = result_reg.data_byte;
    assign has_data     = result_reg.has_data;
    assign end_of_frame = result_reg.end_of_frame;
    assign hdr_checksum = result_reg.hdr_checksum;
    assign hdr_flag     = result_reg.hdr_flag;
    assign hdr_type     = result_reg.hdr_type;
    assign hdr_command  = result_reg.hdr_command;
    assign frame_length = result_reg.frame_length;

`ifndef NO_ASSERTIONS
    // An empty-frame notice always closes its frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_reg.has_data |-> result_reg.end_of_frame)
        else $error("empty-frame result without end_of_frame");

    // A payload byte accepted always yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (phase_reg == mlfp_pkg::PH_PAYLOAD) |=> out_valid_reg)
        else $error("payload byte produced no result");

    // The input side is held back only by a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with empty output register");

    // While streaming payload, the byte count stays below the declared length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mlfp_pkg::PH_PAYLOAD) |-> (count_reg < length_reg))
        else $error("payload count reached frame length");
`endif

endmodule

`default_nettype wire
